@@ rtl/core/nws_pkg.sv @@
// ----------------------------------------------------------------------------
// nws_pkg
// Shared types, constants and the sigmoid lookup table for the neuron block.
// ----------------------------------------------------------------------------
package nws_pkg;

  localparam int unsigned MAX_FAN_IN  = 64;
  localparam int unsigned IDX_W       = $clog2(MAX_FAN_IN);
  localparam int unsigned FAN_W       = $clog2(MAX_FAN_IN + 1);
  localparam int unsigned FAN_CFG_W   = 7;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 7;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned VAL_W       = 16;
  localparam int unsigned ACT_W       = 16;
  localparam int unsigned FRAC_W      = 12;
  localparam int unsigned PROD_W      = 2 * VAL_W;
  localparam int unsigned ACC_W       = PROD_W + IDX_W + 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned SIG_ENTRIES = 256;
  localparam int unsigned SIG_IDX_W   = $clog2(SIG_ENTRIES);

  localparam logic signed [VAL_W-1:0] ONE_Q412 = VAL_W'(4096);
  localparam logic signed [VAL_W-1:0] VAL_MAX  = VAL_W'(32767);
  localparam logic signed [VAL_W-1:0] VAL_MIN  = VAL_W'(-32768);

  localparam logic [FAN_CFG_W-1:0] FAN_RESET = FAN_CFG_W'(MAX_FAN_IN);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAN_IN    = 1'b0,
    CFG_BIAS_MODE = 1'b1
  } cfg_reg_e;

  typedef enum logic [OP_W-1:0] {
    OP_SET_INPUT   = 3'd0,
    OP_LOAD_WEIGHT = 3'd1,
    OP_ADD_DELTA   = 3'd2,
    OP_EVALUATE    = 3'd3,
    OP_READ_ENTRY  = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    K_WR_IN,
    K_WR_W,
    K_ADD,
    K_READ,
    K_EVAL,
    K_BIAS,
    K_ERR,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e                   kind;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_EVAL,
    ST_DRAIN,
    ST_SAT,
    ST_OUT
  } state_e;

  // e^(-2^k / 4096) in Q0.24
  localparam logic [0:15][31:0] EXP_BIT_Q24 = {
    32'd16773121, 32'd16769026, 32'd16760840, 32'd16744480,
    32'd16711808, 32'd16646655, 32'd16517109, 32'd16261035,
    32'd15760736, 32'd14805841, 32'd13066109, 32'd10175896,
    32'd6171993,  32'd2270549,  32'd307285,   32'd5628
  };

  typedef logic [SIG_ENTRIES-1:0][ACT_W-1:0] sig_tab_t;

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], n[k]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [ACT_W-1:0] sigmoid_at(int m);
    logic [31:0] mag;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] q;
    mag = (m < 0) ? 32'(-m) : 32'(m);
    e   = 64'd16777216;
    for (int k = 0; k < 16; k++) begin
      if (mag[k]) begin
        e = (e * 64'(EXP_BIT_Q24[k]) + 64'd8388608) >> 24;
      end
    end
    d = 64'd16777216 + e;
    if (m >= 0) begin
      q = udiv64((64'd1 << 40) + (d >> 1), d);
    end else begin
      q = udiv64((e << 16) + (d >> 1), d);
    end
    return (q > 64'd65535) ? 16'hFFFF : q[ACT_W-1:0];
  endfunction

  function automatic sig_tab_t build_sig_table();
    sig_tab_t t;
    int       m;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      m    = ((2 * i + 1) * 32768) / SIG_ENTRIES - 32768;
      t[i] = sigmoid_at(m);
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

@@ rtl/core/neuron_weighted_sum_sigmoid.sv @@
// ----------------------------------------------------------------------------
// neuron_weighted_sum_sigmoid
// Sigmoid neuron with input, weight and last-delta stores (Q4.12).
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one command word: set input,
// load weight, add delta, evaluate or read entry. Every word gives exactly
// one result word on the output channel (out_valid_o / out_stall_i).
// Decode and index check run in the front; a two-word queue sits between
// it and the execution unit, so the input keeps flowing while a result waits.
// Path from queue to result, per kind of word:
//   store writes, errors, bias evaluate, unknown codes: result loaded from idle
//   read entry and add delta: one store read, then write (access state)
//   evaluate: MAC loop, drain, saturate, table lookup; one multiply-accumulate
//   per cycle through a single store read port, multiplier and accumulator.
// Throughput: one word per cycle for writes while the output drains;
// evaluate occupies the execution unit for its whole MAC loop.
// Reset: fan_in 64, bias_mode 0, inputs 0, weights 1.0, deltas 0; per-entry
// valid flags give the reset values, no clearing pass is needed.
// A stalled output holds its word; execution waits, then the queue fills
// and in_stall_o rises. Configuration writes only while idle.
// ----------------------------------------------------------------------------
module neuron_weighted_sum_sigmoid (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [nws_pkg::OP_W-1:0]           opcode_i,
  input  logic [nws_pkg::IDX_W-1:0]          entry_index_i,
  input  logic signed [nws_pkg::VAL_W-1:0]   operand_value_i,
  input  logic                               cfg_we_i,
  input  logic [nws_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [nws_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [nws_pkg::ACT_W-1:0]          activation_o,
  output logic signed [nws_pkg::VAL_W-1:0]   entry_input_o,
  output logic signed [nws_pkg::VAL_W-1:0]   entry_weight_o,
  output logic signed [nws_pkg::VAL_W-1:0]   entry_delta_o,
  output logic                               index_error_o
);

  logic                      q_full;
  logic                      q_push;
  nws_pkg::cmd_t             q_wcmd;
  nws_pkg::cmd_t             q_rcmd;
  logic                      q_vld;
  logic                      q_pop;
  logic [nws_pkg::FAN_W-1:0] fan_used;

  nws_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .entry_index_i   (entry_index_i),
    .operand_value_i (operand_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_wcmd),
    .fan_used_o      (fan_used)
  );

  nws_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_wcmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .cmd_o  (q_rcmd),
    .vld_o  (q_vld)
  );

  nws_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (q_rcmd),
    .cmd_vld_i      (q_vld),
    .cmd_pop_o      (q_pop),
    .fan_used_i     (fan_used),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .activation_o   (activation_o),
    .entry_input_o  (entry_input_o),
    .entry_weight_o (entry_weight_o),
    .entry_delta_o  (entry_delta_o),
    .index_error_o  (index_error_o)
  );

endmodule

@@ rtl/core/nws_ram.sv @@
// ----------------------------------------------------------------------------
// nws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nws_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/nws_front.sv @@
// ----------------------------------------------------------------------------
// nws_front
// Configuration registers, command decode and index check, queue push.
// ----------------------------------------------------------------------------
module nws_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [nws_pkg::OP_W-1:0]               opcode_i,
  input  logic [nws_pkg::IDX_W-1:0]              entry_index_i,
  input  logic signed [nws_pkg::VAL_W-1:0]       operand_value_i,
  input  logic                                   cfg_we_i,
  input  logic [nws_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [nws_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                                   q_full_i,
  output logic                                   q_push_o,
  output nws_pkg::cmd_t                          q_cmd_o,
  output logic [nws_pkg::FAN_W-1:0]              fan_used_o
);

  logic [nws_pkg::FAN_CFG_W-1:0] fan_q;
  logic                          bias_q;
  logic [nws_pkg::FAN_W-1:0]     fan_used;
  logic                          bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_q  <= nws_pkg::FAN_RESET;
      bias_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nws_pkg::CFG_FAN_IN:    fan_q  <= cfg_wdata_i[nws_pkg::FAN_CFG_W-1:0];
        nws_pkg::CFG_BIAS_MODE: bias_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign fan_used = (32'(fan_q) > nws_pkg::MAX_FAN_IN) ?
                    nws_pkg::FAN_W'(nws_pkg::MAX_FAN_IN) : nws_pkg::FAN_W'(fan_q);
  assign bad      = 32'(entry_index_i) >= 32'(fan_used);

  always_comb begin
    q_cmd_o.index = entry_index_i;
    q_cmd_o.value = operand_value_i;
    unique case (opcode_i)
      nws_pkg::OP_SET_INPUT:   q_cmd_o.kind = bad ? nws_pkg::K_ERR : nws_pkg::K_WR_IN;
      nws_pkg::OP_LOAD_WEIGHT: q_cmd_o.kind = bad ? nws_pkg::K_ERR : nws_pkg::K_WR_W;
      nws_pkg::OP_ADD_DELTA:   q_cmd_o.kind = bad ? nws_pkg::K_ERR : nws_pkg::K_ADD;
      nws_pkg::OP_READ_ENTRY:  q_cmd_o.kind = bad ? nws_pkg::K_ERR : nws_pkg::K_READ;
      nws_pkg::OP_EVALUATE:    q_cmd_o.kind = bias_q ? nws_pkg::K_BIAS : nws_pkg::K_EVAL;
      default:                 q_cmd_o.kind = nws_pkg::K_NOP;
    endcase
  end

  assign q_push_o   = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign fan_used_o = fan_used;

endmodule

@@ rtl/core/nws_fifo.sv @@
// ----------------------------------------------------------------------------
// nws_fifo
// Short command queue between decode and execution.
// ----------------------------------------------------------------------------
module nws_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nws_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output nws_pkg::cmd_t cmd_o,
  output logic          vld_o
);

  nws_pkg::cmd_t                mem_q [nws_pkg::QUEUE_DEPTH];
  logic [nws_pkg::QPTR_W-1:0]   wp_q;
  logic [nws_pkg::QPTR_W-1:0]   rp_q;
  logic [nws_pkg::QCNT_W-1:0]   cnt_q;
  logic                         do_push;
  logic                         do_pop;

  assign full_o  = cnt_q == nws_pkg::QCNT_W'(nws_pkg::QUEUE_DEPTH);
  assign vld_o   = cnt_q != '0;
  assign cmd_o   = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == nws_pkg::QPTR_W'(nws_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == nws_pkg::QPTR_W'(nws_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/nws_back.sv @@
// ----------------------------------------------------------------------------
// nws_back
// Executes queued commands: store writes, saturating weight update, entry
// read-back, and the multiply-accumulate loop with sigmoid lookup.
// ----------------------------------------------------------------------------
module nws_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  nws_pkg::cmd_t                      cmd_i,
  input  logic                               cmd_vld_i,
  output logic                               cmd_pop_o,
  input  logic [nws_pkg::FAN_W-1:0]          fan_used_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [nws_pkg::ACT_W-1:0]          activation_o,
  output logic signed [nws_pkg::VAL_W-1:0]   entry_input_o,
  output logic signed [nws_pkg::VAL_W-1:0]   entry_weight_o,
  output logic signed [nws_pkg::VAL_W-1:0]   entry_delta_o,
  output logic                               index_error_o
);

  typedef struct packed {
    logic [nws_pkg::ACT_W-1:0]        activation;
    logic signed [nws_pkg::VAL_W-1:0] entry_input;
    logic signed [nws_pkg::VAL_W-1:0] entry_weight;
    logic signed [nws_pkg::VAL_W-1:0] entry_delta;
    logic                             index_error;
  } res_t;

  nws_pkg::state_e state_q, state_d;

  logic [nws_pkg::MAX_FAN_IN-1:0] in_vld_q, w_vld_q, d_vld_q;
  nws_pkg::cmd_t                  cur_q;
  logic [nws_pkg::FAN_W-1:0]      cnt_q;
  logic [nws_pkg::IDX_W-1:0]      rd_idx_q;
  logic                           rd_v_q, prod_v_q;
  logic signed [nws_pkg::PROD_W-1:0] prod_q;
  logic signed [nws_pkg::ACC_W-1:0]  acc_q;
  logic [nws_pkg::SIG_IDX_W-1:0]  tidx_q;
  logic                           out_vld_q;
  res_t                           out_q;

  logic                           out_free;
  logic                           re;
  logic [nws_pkg::IDX_W-1:0]      raddr;
  logic                           in_we, w_we, d_we;
  logic [nws_pkg::IDX_W-1:0]      waddr;
  logic signed [nws_pkg::VAL_W-1:0] w_wdata;
  logic                           out_load;
  res_t                           out_d;
  logic                           cnt_inc, eval_start, cur_load;

  logic [nws_pkg::VAL_W-1:0]        in_rdata, w_rdata, d_rdata;
  logic signed [nws_pkg::VAL_W-1:0] in_val, w_val, d_val;
  logic signed [nws_pkg::VAL_W:0]   add_sum;
  logic signed [nws_pkg::VAL_W-1:0] add_sat;
  logic signed [nws_pkg::ACC_W-1:0] acc_sh;
  logic signed [nws_pkg::VAL_W-1:0] net;
  logic                             eval_more;

  nws_ram #(.WIDTH(nws_pkg::VAL_W), .DEPTH(nws_pkg::MAX_FAN_IN)) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (in_we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (in_rdata)
  );

  nws_ram #(.WIDTH(nws_pkg::VAL_W), .DEPTH(nws_pkg::MAX_FAN_IN)) u_w_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (waddr),
    .wdata_i (w_wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (w_rdata)
  );

  nws_ram #(.WIDTH(nws_pkg::VAL_W), .DEPTH(nws_pkg::MAX_FAN_IN)) u_d_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (waddr),
    .wdata_i (cur_q.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (d_rdata)
  );

  // entries never written read as their reset value
  assign in_val = in_vld_q[rd_idx_q] ? in_rdata : '0;
  assign w_val  = w_vld_q[rd_idx_q]  ? w_rdata  : nws_pkg::ONE_Q412;
  assign d_val  = d_vld_q[rd_idx_q]  ? d_rdata  : '0;

  assign add_sum = (nws_pkg::VAL_W + 1)'(w_val) + (nws_pkg::VAL_W + 1)'(cur_q.value);
  assign add_sat = (add_sum[nws_pkg::VAL_W] != add_sum[nws_pkg::VAL_W-1]) ?
                   (add_sum[nws_pkg::VAL_W] ? nws_pkg::VAL_MIN : nws_pkg::VAL_MAX) :
                   add_sum[nws_pkg::VAL_W-1:0];

  // floor to Q4.12, saturate
  assign acc_sh = acc_q >>> nws_pkg::FRAC_W;
  assign net    = (acc_sh > nws_pkg::ACC_W'(nws_pkg::VAL_MAX)) ? nws_pkg::VAL_MAX :
                  (acc_sh < nws_pkg::ACC_W'(nws_pkg::VAL_MIN)) ? nws_pkg::VAL_MIN :
                  acc_sh[nws_pkg::VAL_W-1:0];

  assign out_free  = !out_vld_q || !out_stall_i;
  assign eval_more = cnt_q < fan_used_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nws_pkg::ST_IDLE: begin
        if (cmd_vld_i) begin
          unique case (cmd_i.kind) inside
            nws_pkg::K_ADD, nws_pkg::K_READ: state_d = nws_pkg::ST_ACCESS;
            nws_pkg::K_EVAL:                 state_d = nws_pkg::ST_EVAL;
            default:                         state_d = nws_pkg::ST_IDLE;
          endcase
        end
      end
      nws_pkg::ST_ACCESS: if (out_free) state_d = nws_pkg::ST_IDLE;
      nws_pkg::ST_EVAL:   if (!eval_more) state_d = nws_pkg::ST_DRAIN;
      nws_pkg::ST_DRAIN:  if (!rd_v_q && !prod_v_q) state_d = nws_pkg::ST_SAT;
      nws_pkg::ST_SAT:    state_d = nws_pkg::ST_OUT;
      nws_pkg::ST_OUT:    if (out_free) state_d = nws_pkg::ST_IDLE;
      default:            state_d = nws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    re         = 1'b0;
    raddr      = cmd_i.index;
    in_we      = 1'b0;
    w_we       = 1'b0;
    d_we       = 1'b0;
    waddr      = cmd_i.index;
    w_wdata    = cmd_i.value;
    out_load   = 1'b0;
    out_d      = '0;
    cnt_inc    = 1'b0;
    eval_start = 1'b0;
    cur_load   = 1'b0;
    unique case (state_q)
      nws_pkg::ST_IDLE: begin
        if (cmd_vld_i) begin
          unique case (cmd_i.kind) inside
            nws_pkg::K_WR_IN: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                in_we     = 1'b1;
                out_load  = 1'b1;
              end
            end
            nws_pkg::K_WR_W: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                w_we      = 1'b1;
                out_load  = 1'b1;
              end
            end
            nws_pkg::K_ADD, nws_pkg::K_READ: begin
              cmd_pop_o = 1'b1;
              re        = 1'b1;
              cur_load  = 1'b1;
            end
            nws_pkg::K_EVAL: begin
              cmd_pop_o  = 1'b1;
              eval_start = 1'b1;
            end
            nws_pkg::K_BIAS: begin
              if (out_free) begin
                cmd_pop_o        = 1'b1;
                out_load         = 1'b1;
                out_d.activation = '1;
              end
            end
            nws_pkg::K_ERR: begin
              if (out_free) begin
                cmd_pop_o         = 1'b1;
                out_load          = 1'b1;
                out_d.index_error = 1'b1;
              end
            end
            default: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                out_load  = 1'b1;
              end
            end
          endcase
        end
      end
      nws_pkg::ST_ACCESS: begin
        waddr   = cur_q.index;
        w_wdata = add_sat;
        if (out_free) begin
          out_load = 1'b1;
          if (cur_q.kind == nws_pkg::K_ADD) begin
            w_we = 1'b1;
            d_we = 1'b1;
          end else begin
            out_d.entry_input  = in_val;
            out_d.entry_weight = w_val;
            out_d.entry_delta  = d_val;
          end
        end
      end
      nws_pkg::ST_EVAL: begin
        raddr = cnt_q[nws_pkg::IDX_W-1:0];
        if (eval_more) begin
          re      = 1'b1;
          cnt_inc = 1'b1;
        end
      end
      nws_pkg::ST_OUT: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_d.activation = nws_pkg::SIG_TABLE[tidx_q];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nws_pkg::ST_IDLE;
      in_vld_q  <= '0;
      w_vld_q   <= '0;
      d_vld_q   <= '0;
      cnt_q     <= '0;
      rd_v_q    <= 1'b0;
      prod_v_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= cnt_inc;
      prod_v_q <= rd_v_q;
      if (in_we) in_vld_q[waddr] <= 1'b1;
      if (w_we)  w_vld_q[waddr]  <= 1'b1;
      if (d_we)  d_vld_q[waddr]  <= 1'b1;
      if (eval_start) begin
        cnt_q <= '0;
      end else if (cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_load) cur_q <= cmd_i;
    if (re) rd_idx_q <= raddr;
    if (rd_v_q) prod_q <= nws_pkg::PROD_W'(in_val) * nws_pkg::PROD_W'(w_val);
    if (eval_start) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + nws_pkg::ACC_W'(prod_q);
    end
    if (state_q == nws_pkg::ST_SAT) begin
      tidx_q <= {~net[nws_pkg::VAL_W-1],
                 net[nws_pkg::VAL_W-2 -: (nws_pkg::SIG_IDX_W - 1)]};
    end
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o    = out_vld_q;
  assign activation_o   = out_q.activation;
  assign entry_input_o  = out_q.entry_input;
  assign entry_weight_o = out_q.entry_weight;
  assign entry_delta_o  = out_q.entry_delta;
  assign index_error_o  = out_q.index_error;

endmodule

@@ verif/neuron_checker.sv @@
// ----------------------------------------------------------------------------
// neuron_checker
// Watches the command and result channels of the sigmoid neuron, keeps its
// own copy of the stores and registers, predicts every result word and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module neuron_checker
  import nws_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic [IDX_W-1:0]         entry_index_i,
  input  logic signed [VAL_W-1:0]  operand_value_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [ACT_W-1:0]         activation_i,
  input  logic signed [VAL_W-1:0]  entry_input_i,
  input  logic signed [VAL_W-1:0]  entry_weight_i,
  input  logic signed [VAL_W-1:0]  entry_delta_i,
  input  logic                     index_error_i,
  output int                       mismatch_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // e^(-2^k / 4096) in Q0.24
  localparam logic [0:15][31:0] EXP_NEG_POW2 = {
    32'd16773121, 32'd16769026, 32'd16760840, 32'd16744480,
    32'd16711808, 32'd16646655, 32'd16517109, 32'd16261035,
    32'd15760736, 32'd14805841, 32'd13066109, 32'd10175896,
    32'd6171993,  32'd2270549,  32'd307285,   32'd5628
  };

  typedef struct packed {
    logic [ACT_W-1:0]        activation;
    logic signed [VAL_W-1:0] stored_input;
    logic signed [VAL_W-1:0] stored_weight;
    logic signed [VAL_W-1:0] stored_delta;
    logic                    index_error;
  } neuron_word_t;

  logic [FAN_CFG_W-1:0]    fan_in_q;
  logic                    bias_q;
  logic signed [VAL_W-1:0] inputs_m  [MAX_FAN_IN];
  logic signed [VAL_W-1:0] weights_m [MAX_FAN_IN];
  logic signed [VAL_W-1:0] deltas_m  [MAX_FAN_IN];
  logic [ACT_W-1:0]        sigmoid_lut [SIG_ENTRIES];
  neuron_word_t            expected_words [$];
  int                      mismatch_count = 0;
  int                      pending_count = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = pending_count;

  // sigmoid at each bin midpoint of [-8, 8)
  initial begin
    longint unsigned e, d, q;
    int              m;
    logic [31:0]     mag;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      m   = ((2 * i + 1) * 32768) / SIG_ENTRIES - 32768;
      mag = (m < 0) ? 32'(-m) : 32'(m);
      e   = 64'd1 << 24;
      for (int k = 0; k < 16; k++) begin
        if (mag[k]) e = (e * EXP_NEG_POW2[k] + (64'd1 << 23)) >> 24;
      end
      d = (64'd1 << 24) + e;
      if (m >= 0) q = ((64'd1 << 40) + (d >> 1)) / d;
      else        q = ((e << 16) + (d >> 1)) / d;
      sigmoid_lut[i] = (q > 64'd65535) ? '1 : q[ACT_W-1:0];
    end
  end

  function automatic longint clamp_q412(longint v);
    if (v > VAL_MAX) return longint'(VAL_MAX);
    if (v < VAL_MIN) return longint'(VAL_MIN);
    return v;
  endfunction

  function automatic logic [ACT_W-1:0] neuron_activation(int unsigned n);
    longint      acc;
    longint      net;
    int unsigned lut_idx;
    if (bias_q) return '1;
    acc = 0;
    for (int unsigned i = 0; i < n; i++) begin
      acc += longint'(inputs_m[i]) * longint'(weights_m[i]);
    end
    net     = clamp_q412(acc >>> FRAC_W);
    lut_idx = int'(((net - longint'(VAL_MIN)) * SIG_ENTRIES) >>> VAL_W);
    if (lut_idx >= SIG_ENTRIES) lut_idx = SIG_ENTRIES - 1;
    return sigmoid_lut[lut_idx];
  endfunction

  function automatic neuron_word_t step_neuron(logic [OP_W-1:0] op,
                                               logic [IDX_W-1:0] idx,
                                               logic signed [VAL_W-1:0] val);
    neuron_word_t w;
    int unsigned  n;
    w = '0;
    n = (fan_in_q > MAX_FAN_IN) ? MAX_FAN_IN : fan_in_q;
    case (op)
      OP_SET_INPUT, OP_LOAD_WEIGHT, OP_ADD_DELTA, OP_READ_ENTRY: begin
        if (idx >= n) begin
          w.index_error = 1'b1;
        end else begin
          case (op)
            OP_SET_INPUT:   inputs_m[idx] = val;
            OP_LOAD_WEIGHT: weights_m[idx] = val;
            OP_ADD_DELTA: begin
              weights_m[idx] = VAL_W'(clamp_q412(longint'(weights_m[idx]) + longint'(val)));
              deltas_m[idx]  = val;
            end
            default: begin
              w.stored_input  = inputs_m[idx];
              w.stored_weight = weights_m[idx];
              w.stored_delta  = deltas_m[idx];
            end
          endcase
        end
      end
      OP_EVALUATE: w.activation = neuron_activation(n);
      default: ;
    endcase
    return w;
  endfunction

  task automatic compare_field(string field, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    neuron_word_t want;
    if (!rst_ni) begin
      fan_in_q = FAN_RESET;
      bias_q   = 1'b0;
      for (int i = 0; i < MAX_FAN_IN; i++) begin
        inputs_m[i]  = '0;
        weights_m[i] = ONE_Q412;
        deltas_m[i]  = '0;
      end
      expected_words.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with none expected, expected none, got act %0d err %0d",
                   $time, activation_i, index_error_i);
        end else begin
          want = expected_words.pop_front();
          compare_field("activation", longint'(want.activation), longint'(activation_i));
          compare_field("entry_input", longint'($signed(want.stored_input)),
                        longint'(entry_input_i));
          compare_field("entry_weight", longint'($signed(want.stored_weight)),
                        longint'(entry_weight_i));
          compare_field("entry_delta", longint'($signed(want.stored_delta)),
                        longint'(entry_delta_i));
          compare_field("index_error", longint'(want.index_error), longint'(index_error_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_words.insert(expected_words.size(),
                              step_neuron(opcode_i, entry_index_i, operand_value_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FAN_IN:    fan_in_q = cfg_wdata_i[FAN_CFG_W-1:0];
          CFG_BIAS_MODE: bias_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
    pending_count = expected_words.size();
  end

endmodule

@@ verif/neuron_weighted_sum_sigmoid_tb.sv @@
// ----------------------------------------------------------------------------
// neuron_weighted_sum_sigmoid_tb
// Drives command words into the sigmoid neuron under several fan-in and bias
// settings: a directed opening on extremes and error cases, then random
// write/evaluate/read sequences mixed with noise, with random back-pressure.
// ----------------------------------------------------------------------------
module neuron_weighted_sum_sigmoid_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nws_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_W'(OP_READ_ENTRY + 1);
  localparam logic [OP_W-1:0] OP_CODE_TOP     = '1;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [OP_W-1:0]         opcode_i = '0;
  logic [IDX_W-1:0]        entry_index_i = '0;
  logic signed [VAL_W-1:0] operand_value_i = '0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [ACT_W-1:0]        activation_o;
  logic signed [VAL_W-1:0] entry_input_o;
  logic signed [VAL_W-1:0] entry_weight_o;
  logic signed [VAL_W-1:0] entry_delta_o;
  logic                    index_error_o;

  int          mismatches;
  int          pending_words;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned evals_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cur_fan = MAX_FAN_IN;
  bit          quiet = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  neuron_weighted_sum_sigmoid DUT (.*);

  neuron_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .opcode_i        (opcode_i),
    .entry_index_i   (entry_index_i),
    .operand_value_i (operand_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .activation_i    (activation_o),
    .entry_input_i   (entry_input_o),
    .entry_weight_i  (entry_weight_o),
    .entry_delta_i   (entry_delta_o),
    .index_error_i   (index_error_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending_words)
  );

  function automatic logic signed [VAL_W-1:0] pick_value();
    int t;
    case ($urandom_range(0, 3))
      0: t = int'($urandom);
      1: t = int'($urandom_range(0, 16383)) - 8192;
      2: t = int'($urandom_range(0, 2047)) - 1024;
      default: begin
        case ($urandom_range(0, 4))
          0: t = VAL_MAX;
          1: t = VAL_MIN;
          2: t = ONE_Q412;
          3: t = -ONE_Q412;
          default: t = 0;
        endcase
      end
    endcase
    return t[VAL_W-1:0];
  endfunction

  task automatic send_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                           logic signed [VAL_W-1:0] val);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    entry_index_i   <= idx;
    operand_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    if (op == OP_EVALUATE) evals_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_words != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (r == CFG_FAN_IN) begin
      cur_fan = (data > MAX_FAN_IN) ? MAX_FAN_IN : data;
    end
  endtask

  task automatic random_words(int unsigned n_words);
    int unsigned     done_words;
    int unsigned     burst;
    logic [OP_W-1:0] op;
    done_words = 0;
    while (done_words < n_words) begin
      if (cur_fan > 0 && $urandom_range(0, 99) < 80) begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          case ($urandom_range(0, 2))
            0: op = OP_SET_INPUT;
            1: op = OP_LOAD_WEIGHT;
            default: op = OP_ADD_DELTA;
          endcase
          send_word(op, IDX_W'($urandom_range(0, cur_fan - 1)), pick_value());
        end
        send_word(OP_EVALUATE, IDX_W'($urandom), VAL_W'($urandom));
        send_word(OP_READ_ENTRY, IDX_W'($urandom_range(0, cur_fan - 1)), VAL_W'($urandom));
        done_words += burst + 2;
      end else begin
        send_word(OP_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
        done_words++;
      end
    end
  endtask

  task automatic run_phase(logic [FAN_CFG_W-1:0] fan, logic bias, int unsigned n_words,
                           bit stall_burst);
    write_reg(CFG_FAN_IN, CFG_DATA_W'(fan));
    write_reg(CFG_BIAS_MODE, CFG_DATA_W'(bias));
    settings_used++;
    if (stall_burst) hold_off_req = 1'b1;
    random_words(n_words);
  endtask

  // receiver back-pressure
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 6);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending_words);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    settings_used = 1;

    // reset contents, extremes, saturation both ways
    send_word(OP_READ_ENTRY, 0, 0);
    send_word(OP_READ_ENTRY, 63, 0);
    send_word(OP_EVALUATE, 63, VAL_MIN);
    send_word(OP_SET_INPUT, 0, VAL_MAX);
    send_word(OP_SET_INPUT, 63, VAL_MIN);
    send_word(OP_LOAD_WEIGHT, 0, VAL_MAX);
    send_word(OP_LOAD_WEIGHT, 63, VAL_MIN);
    send_word(OP_EVALUATE, 0, 0);
    send_word(OP_ADD_DELTA, 1, VAL_MAX);
    send_word(OP_ADD_DELTA, 2, VAL_MIN);
    send_word(OP_ADD_DELTA, 2, VAL_MIN);
    send_word(OP_SET_INPUT, 1, VAL_MAX);
    send_word(OP_SET_INPUT, 2, VAL_MAX);
    send_word(OP_LOAD_WEIGHT, 0, 0);
    send_word(OP_EVALUATE, 0, 0);
    send_word(OP_READ_ENTRY, 1, 0);
    send_word(OP_READ_ENTRY, 2, 0);
    send_word(OP_FIRST_UNUSED, 5, VAL_MAX);
    send_word(OP_CODE_TOP, 63, VAL_MIN);

    // out-of-range indexes
    write_reg(CFG_FAN_IN, 4);
    send_word(OP_SET_INPUT, 4, ONE_Q412);
    send_word(OP_READ_ENTRY, 63, 0);
    send_word(OP_ADD_DELTA, 5, ONE_Q412);
    send_word(OP_LOAD_WEIGHT, 3, ONE_Q412);
    send_word(OP_EVALUATE, 0, 0);

    // empty fan-in, oversized fan-in, bias mode
    write_reg(CFG_FAN_IN, 0);
    send_word(OP_SET_INPUT, 0, ONE_Q412);
    send_word(OP_EVALUATE, 0, 0);
    write_reg(CFG_FAN_IN, 127);
    write_reg(CFG_BIAS_MODE, 1);
    send_word(OP_READ_ENTRY, 63, 0);
    send_word(OP_EVALUATE, 0, 0);
    settings_used += 3;

    run_phase(64, 1'b0, 150, 1'b1);
    run_phase(1, 1'b0, 90, 1'b0);
    quiet = 1'b1;
    run_phase(17, 1'b0, 130, 1'b0);
    quiet = 1'b0;
    run_phase(127, 1'b0, 130, 1'b0);
    run_phase(0, 1'b0, 60, 1'b0);
    run_phase(64, 1'b1, 90, 1'b0);
    run_phase(5, 1'b0, 120, 1'b0);
    run_phase(33, 1'b1, 60, 1'b0);
    run_phase(48, 1'b0, 200, 1'b0);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d command words (%0d evaluates) across %0d register settings,",
             words_sent, evals_sent, settings_used);
    $display("with random stalls on both sides and a %0d-cycle result hold-off.", HOLD_CYCLES);
    if (mismatches == 0 && pending_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
